// ----- rtl/prt_pkg.sv -----
// Shared constants and codes for the priority request table.
`timescale 1ns / 1ps

package prt_pkg;

    localparam int PENDING_DEPTH_DEF = 32;
    localparam int DONE_DEPTH_DEF    = 64;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 2;
    localparam int OP_W   = 3;
    localparam int STAT_W = 3;
    localparam int WORD_W = 24;

    localparam logic [PRIO_W-1:0] PRIO_MIN = 2'd1;
    localparam logic [PRIO_W-1:0] PRIO_MAX = 2'd3;

    localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_W-1:0] OP_UPDATE  = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [OP_W-1:0] OP_PROCESS = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADPRIO  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd5;
    localparam logic [STAT_W-1:0] ST_DONEFULL = 3'd6;

endpackage

// ----- rtl/priority_request_table_core.sv -----
// Priority request table: pending and completed stores scanned by a sequencer.
//
//  channel | dir | word (low bit up)
//  s_axis  | in  | opcode[2:0], request_id[18:3], priority_req[20:19]
//  m_axis  | out | status[2:0], result_id[18:3], result_priority[20:19]
//
// A result shows once the P pending entries are scanned and, for add only, the
// D completed entries; the next word is taken once that result has moved to
// the output register. Delete and process first shift the S entries above the
// removed one down. Every step goes through the one read port of each RAM.
// Reset clears the counts, the sequencer and the output valid only; RAM contents are not cleared.
// One operation at a time; a result waits in the output register while the
// next word is accepted.
`timescale 1ns / 1ps

module priority_request_table_core
    import prt_pkg::*;
#(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int DONE_DEPTH    = DONE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // opcode[2:0], request_id[18:3], priority_req[20:19]
    input  logic [WORD_W-1:0] s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // status[2:0], result_id[18:3], result_priority[20:19]
    output logic [WORD_W-1:0] m_tdata
);

    localparam int PIW = $clog2(PENDING_DEPTH);
    localparam int DIW = $clog2(DONE_DEPTH);
    localparam int PEW = ID_W + PRIO_W;
    localparam logic [PIW:0] PFULL = (PIW+1)'(PENDING_DEPTH);
    localparam logic [DIW:0] DFULL = (DIW+1)'(DONE_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_P_RD  = 8'b00000010,
        S_P_CHK = 8'b00000100,
        S_D_RD  = 8'b00001000,
        S_D_CHK = 8'b00010000,
        S_EXEC  = 8'b00100000,
        S_SH_RD = 8'b01000000,
        S_SH_WR = 8'b10000000
    } state_t;

    state_t             state_reg, state_next;
    logic               fin_reg, fin_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [PRIO_W-1:0]  pr_reg, pr_next;
    logic [PIW-1:0]     idx_reg, idx_next;
    logic [DIW-1:0]     didx_reg, didx_next;
    logic               found_reg, found_next;
    logic               dup_reg, dup_next;
    logic [PIW-1:0]     slot_reg, slot_next;
    logic [PRIO_W-1:0]  slot_prio_reg, slot_prio_next;
    logic [PIW-1:0]     best_slot_reg, best_slot_next;
    logic [ID_W-1:0]    best_id_reg, best_id_next;
    logic [PRIO_W-1:0]  best_prio_reg, best_prio_next;
    logic [PIW-1:0]     sh_idx_reg, sh_idx_next;
    logic [PIW:0]       pcount_reg, pcount_next;
    logic [DIW:0]       dcount_reg, dcount_next;
    logic [STAT_W-1:0]  res_st_reg, res_st_next;
    logic [ID_W-1:0]    res_id_reg, res_id_next;
    logic [PRIO_W-1:0]  res_pr_reg, res_pr_next;
    logic               m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]  m_data_reg, m_data_next;

    logic               p_we;
    logic [PIW-1:0]     p_waddr, p_raddr;
    logic [PEW-1:0]     p_wdata, p_rdata;
    logic               d_we;
    logic [DIW-1:0]     d_waddr, d_raddr;
    logic [ID_W-1:0]    d_rdata;

    logic               accept;
    logic               out_free;
    logic               prio_ok;
    logic [ID_W-1:0]    rd_id;
    logic [PRIO_W-1:0]  rd_pr;

    prt_ram #(.WIDTH(PEW), .DEPTH(PENDING_DEPTH)) u_pend_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    prt_ram #(.WIDTH(ID_W), .DEPTH(DONE_DEPTH)) u_done_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (best_id_reg),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    assign s_tready = (state_reg == S_IDLE) && !fin_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign prio_ok  = (pr_reg >= PRIO_MIN) && (pr_reg <= PRIO_MAX);
    assign rd_id    = p_rdata[PEW-1:PRIO_W];
    assign rd_pr    = p_rdata[PRIO_W-1:0];

    // Sequence the scans, the update and the shift
    always_comb
    begin
        state_next     = state_reg;
        fin_next       = fin_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        pr_next        = pr_reg;
        idx_next       = idx_reg;
        didx_next      = didx_reg;
        found_next     = found_reg;
        dup_next       = dup_reg;
        slot_next      = slot_reg;
        slot_prio_next = slot_prio_reg;
        best_slot_next = best_slot_reg;
        best_id_next   = best_id_reg;
        best_prio_next = best_prio_reg;
        sh_idx_next    = sh_idx_reg;
        pcount_next    = pcount_reg;
        dcount_next    = dcount_reg;
        res_st_next    = res_st_reg;
        res_id_next    = res_id_reg;
        res_pr_next    = res_pr_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        p_we           = 1'b0;
        p_waddr        = pcount_reg[PIW-1:0];
        p_wdata        = {id_reg, pr_reg};
        p_raddr        = idx_reg;
        d_we           = 1'b0;
        d_waddr        = dcount_reg[DIW-1:0];
        d_raddr        = didx_reg;

        // Drop the shown word once taken
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        // Hand the finished result to the output register
        if (fin_reg && out_free)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {3'b000, res_pr_reg, res_id_reg, res_st_reg};
            fin_next     = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = s_tdata[OP_W-1:0];
                    id_next    = s_tdata[OP_W+ID_W-1:OP_W];
                    pr_next    = s_tdata[OP_W+ID_W+PRIO_W-1:OP_W+ID_W];
                    idx_next   = '0;
                    didx_next  = '0;
                    found_next = 1'b0;
                    dup_next   = 1'b0;
                    if (pcount_reg != '0)
                    begin
                        state_next = S_P_RD;
                    end
                    else if (s_tdata[OP_W-1:0] == OP_ADD && dcount_reg != '0)
                    begin
                        state_next = S_D_RD;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_P_RD:
            begin
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                if (rd_id == id_reg && !found_reg)
                begin
                    found_next     = 1'b1;
                    slot_next      = idx_reg;
                    slot_prio_next = rd_pr;
                end
                if (idx_reg == '0 || rd_pr < best_prio_reg)
                begin
                    best_slot_next = idx_reg;
                    best_id_next   = rd_id;
                    best_prio_next = rd_pr;
                end
                idx_next = idx_reg + 1'b1;
                if ({1'b0, idx_reg} + 1'b1 == pcount_reg)
                begin
                    if (op_reg == OP_ADD && dcount_reg != '0)
                    begin
                        state_next = S_D_RD;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
                else
                begin
                    state_next = S_P_RD;
                end
            end
            S_D_RD:
            begin
                state_next = S_D_CHK;
            end
            S_D_CHK:
            begin
                if (d_rdata == id_reg)
                begin
                    dup_next = 1'b1;
                end
                didx_next = didx_reg + 1'b1;
                if ({1'b0, didx_reg} + 1'b1 == dcount_reg)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_D_RD;
                end
            end
            S_EXEC:
            begin
                res_st_next = ST_OK;
                res_id_next = '0;
                res_pr_next = '0;
                state_next  = S_IDLE;
                fin_next    = 1'b1;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (found_reg || dup_reg)
                        begin
                            res_st_next = ST_DUP;
                        end
                        else if (!prio_ok)
                        begin
                            res_st_next = ST_BADPRIO;
                        end
                        else if (pcount_reg == PFULL)
                        begin
                            res_st_next = ST_FULL;
                        end
                        else
                        begin
                            p_we        = 1'b1;
                            pcount_next = pcount_reg + 1'b1;
                            res_id_next = id_reg;
                            res_pr_next = pr_reg;
                        end
                    end
                    OP_UPDATE:
                    begin
                        if (!found_reg)
                        begin
                            res_st_next = ST_NOTFOUND;
                        end
                        else if (!prio_ok)
                        begin
                            res_st_next = ST_BADPRIO;
                        end
                        else
                        begin
                            p_we        = 1'b1;
                            p_waddr     = slot_reg;
                            res_id_next = id_reg;
                            res_pr_next = pr_reg;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (!found_reg)
                        begin
                            res_st_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            res_id_next = id_reg;
                            res_pr_next = slot_prio_reg;
                            pcount_next = pcount_reg - 1'b1;
                            sh_idx_next = slot_reg;
                            fin_next    = 1'b0;
                            state_next  = S_SH_RD;
                        end
                    end
                    OP_PROCESS:
                    begin
                        if (pcount_reg == '0)
                        begin
                            res_st_next = ST_EMPTY;
                        end
                        else if (dcount_reg == DFULL)
                        begin
                            res_st_next = ST_DONEFULL;
                        end
                        else
                        begin
                            d_we        = 1'b1;
                            dcount_next = dcount_reg + 1'b1;
                            res_id_next = best_id_reg;
                            res_pr_next = best_prio_reg;
                            pcount_next = pcount_reg - 1'b1;
                            sh_idx_next = best_slot_reg;
                            fin_next    = 1'b0;
                            state_next  = S_SH_RD;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (!found_reg)
                        begin
                            res_st_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            res_id_next = id_reg;
                            res_pr_next = slot_prio_reg;
                        end
                    end
                    default:
                    begin
                        res_st_next = ST_NOTFOUND;
                    end
                endcase
            end
            S_SH_RD:
            begin
                // Close the gap one entry at a time
                if ({1'b0, sh_idx_reg} < pcount_reg)
                begin
                    p_raddr    = sh_idx_reg + 1'b1;
                    state_next = S_SH_WR;
                end
                else
                begin
                    fin_next   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SH_WR:
            begin
                p_we        = 1'b1;
                p_waddr     = sh_idx_reg;
                p_wdata     = p_rdata;
                sh_idx_next = sh_idx_reg + 1'b1;
                state_next  = S_SH_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fin_reg     <= 1'b0;
            pcount_reg  <= '0;
            dcount_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fin_reg     <= fin_next;
            pcount_reg  <= pcount_next;
            dcount_reg  <= dcount_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        pr_reg        <= pr_next;
        idx_reg       <= idx_next;
        didx_reg      <= didx_next;
        found_reg     <= found_next;
        dup_reg       <= dup_next;
        slot_reg      <= slot_next;
        slot_prio_reg <= slot_prio_next;
        best_slot_reg <= best_slot_next;
        best_id_reg   <= best_id_next;
        best_prio_reg <= best_prio_next;
        sh_idx_reg    <= sh_idx_next;
        res_st_reg    <= res_st_next;
        res_id_reg    <= res_id_next;
        res_pr_reg    <= res_pr_next;
        m_data_reg    <= m_data_next;
    end

    a_pcount_range: assert property (@(posedge clk) disable iff (!rst_n)
        pcount_reg <= PFULL)
        else $error("pending count above depth");

    a_dcount_range: assert property (@(posedge clk) disable iff (!rst_n)
        dcount_reg <= DFULL)
        else $error("completed count above depth");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SH_WR |-> {1'b0, sh_idx_reg} < pcount_reg)
        else $error("shift writes past the live entries");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE || fin_reg)
        else $error("accepted word produced no work");

endmodule

// ----- rtl/prt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module prt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
